@@ hdl/sid_pkg.sv @@
// ----------------------------------------------------------------------------
// sid_pkg: shared definitions for the signed integer to decimal text block
// Widths, character codes, sequencer states and the BCD digit correction.
// ----------------------------------------------------------------------------
package sid_pkg;

   // Width of the two's complement value on the request port.
   localparam int VALUE_BITS  = 32;
   // Decimal digits needed for a magnitude of up to 2^VALUE_BITS - 1.
   // 1233 / 4096 approximates log10(2).
   localparam int DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS    = DIGITS * 4;
   localparam int DIGIT_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CNT_W       = $clog2(VALUE_BITS + 1);

   // ASCII codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Sequencer states of the top level.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_SKIP = 5'b01000,
      ST_EMIT = 5'b10000
   } sid_state_type;

   // Double-dabble correction: a digit of five or more gets three added, so
   // that the following left shift carries into the next digit correctly.
   function automatic logic [3:0] add3(input logic [3:0] digit);
      logic [3:0] result;
      begin
         result = (digit >= 4'd5) ? (digit + 4'd3) : digit;
         return result;
      end
   endfunction

endpackage

@@ hdl/sid_dabble.sv @@
// ----------------------------------------------------------------------------
// sid_dabble: iterative binary to BCD converter
// Shift-add-3 unit that consumes one magnitude bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sid_dabble
   import sid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] magnitude,
   output logic                  busy,
   output logic [BCD_BITS-1:0]   bcd
);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [BCD_BITS-1:0]   bcd_adj;

   // Digit correction, done on all digits in parallel.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = add3(bcd_ff[i*4 +: 4]);
      end
   end

   // Sequencer: load on start, then one shift step per cycle.
   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         mag_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = CNT_W'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
         mag_in  = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign busy = busy_ff;
   assign bcd  = bcd_ff;

endmodule

@@ hdl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one 32-bit two's complement value into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_value) takes one signed
// integer per transaction. The response channel (rsp_valid, rsp_stall,
// rsp_char_code, rsp_last) returns the decimal text, most significant
// character first: a leading '-' for negative values, no leading zeros, a
// single '0' for zero. rsp_last marks the final character of each number.
// Timing: after a request is accepted, the shift-add-3 converter consumes the
// value one bit per cycle and then hands over to the character sequencer.
// Leading zero digits are then skipped at one per cycle (up to 9), the
// sequencer enters the digit output, and each character is loaded into the
// output register once that register is free. Skipped and emitted digits add
// up to ten, so a number gives 1 to 11 characters, and the next request can
// be taken once the last character has been loaded.
// req_stall stays high from acceptance until the last character has been
// loaded into the output register.
// When rsp_stall is high a valid character stays in the output register and
// no other is loaded. A synchronous reset empties the output register and
// returns the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
   import sid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last
);

   sid_state_type          state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_take;
   logic                   out_free;
   logic                   conv_busy;
   logic [BCD_BITS-1:0]    conv_bcd;
   logic [VALUE_BITS-1:0]  magnitude;
   logic [3:0]             digit;

   // Handshake qualifiers.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Unsigned magnitude; the most negative value maps to 2^(VALUE_BITS-1).
   assign magnitude = req_value[VALUE_BITS-1] ? ((~req_value) + VALUE_BITS'(1))
                                              : req_value;

   sid_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .magnitude (magnitude),
      .busy      (conv_busy),
      .bcd       (conv_bcd)
   );

   assign digit = conv_bcd[idx_ff*4 +: 4];

   // Sequencer: convert, optional sign, skip leading zeros, emit digits.
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in   = req_value[VALUE_BITS-1];
               idx_in   = DIGIT_IDX_W'(DIGITS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (!conv_busy) begin
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((digit == 4'd0) && (idx_ff != '0)) begin
               idx_in = idx_ff - DIGIT_IDX_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'b0000, digit};
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - DIGIT_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
